// ===== hw/rtl/ftrm_pkg.sv =====
// ftrm_pkg: types and constants of the frame traffic rate meter
// used by the channel interfaces and by frame_traffic_rate_meter
package ftrm_pkg;

	localparam int unsigned IntervalWidth = 16;
	localparam int unsigned RateWidth = 32;
	localparam int unsigned CountWidth = 64;
	localparam int unsigned CfgIndexWidth = 2;

	localparam logic [RateWidth-1:0] FRAME_SCALE = 32'd1000;

	localparam logic [2:0] OP_TX_FRAME = 3'd0;
	localparam logic [2:0] OP_TX_ERROR = 3'd1;
	localparam logic [2:0] OP_RX_FRAME = 3'd2;
	localparam logic [2:0] OP_CLEAR = 3'd3;
	localparam logic [2:0] OP_TICK = 3'd4;

	localparam logic [CfgIndexWidth-1:0] CFG_INTERVAL_0 = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_INTERVAL_1 = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CFG_INTERVAL_2 = 2'd2;

	localparam logic [IntervalWidth-1:0] INTERVAL_0_RESET = 16'd1;
	localparam logic [IntervalWidth-1:0] INTERVAL_1_RESET = 16'd10;
	localparam logic [IntervalWidth-1:0] INTERVAL_2_RESET = 16'd60;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] frame_size;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         window_index;
		logic signed [31:0] tx_frame_avg;
		logic signed [31:0] rx_frame_avg;
		logic signed [31:0] tx_byte_avg;
		logic signed [31:0] rx_byte_avg;
		logic [63:0]        tx_frames;
		logic [63:0]        rx_frames;
		logic [63:0]        tx_total_bytes;
		logic [63:0]        rx_total_bytes;
		logic [63:0]        tx_error_total;
		logic               last_window;
	} out_word_t;

endpackage

// ===== hw/rtl/ftrm_in_if.sv =====
// ftrm_in_if: valid/ready channel carrying one input word
// depends on ftrm_pkg
interface ftrm_in_if;
	logic              valid;
	logic              ready;
	ftrm_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ftrm_out_if.sv =====
// ftrm_out_if: valid/ready channel carrying one result word
// depends on ftrm_pkg
interface ftrm_out_if;
	logic               valid;
	logic               ready;
	ftrm_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/frame_traffic_rate_meter.sv =====
// frame_traffic_rate_meter: traffic counters and low-pass rate filters, one shared divider
// depends on ftrm_pkg, ftrm_in_if, ftrm_out_if
// a non-tick word goes straight to output; a tick first runs one delta step per counter,
// then per filter a load, 32 divide steps and an update
// every word yields one result word per window; no new word is taken until the last is accepted
// reset: counters, snapshots and rates clear to zero, intervals to 1, 10 and 60
module frame_traffic_rate_meter #(
	parameter int unsigned RATE_WINDOWS = 3
) (
	input  logic                               clk,
	input  logic                               arst_n,
	ftrm_in_if.sink                            in_ch,
	ftrm_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [ftrm_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [ftrm_pkg::IntervalWidth-1:0] cfg_wdata
);

	localparam int unsigned WW = (RATE_WINDOWS > 1) ? $clog2(RATE_WINDOWS) : 1;
	localparam logic [WW-1:0] W_LAST = WW'(RATE_WINDOWS - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DELTA = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_UPD   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]  state_q;
	logic [WW-1:0] w_q;
	logic [1:0]  k_q;
	logic [4:0]  cnt_q;

	logic [15:0] iv0_q, iv1_q, iv2_q;

	logic [63:0] tx_frames_q, rx_frames_q, tx_bytes_q, rx_bytes_q, tx_err_q;
	logic [63:0] snap_q [4];
	logic [3:0][31:0] rate_q [RATE_WINDOWS];

	logic [31:0] d_q;
	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic [15:0] n_q;
	logic        neg_q;

	logic        in_acc;
	logic        out_acc;
	logic [63:0] sel_cnt;
	logic [31:0] delta_raw;
	logic [31:0] delta_val;
	logic [3:0][31:0] row_rd;
	logic [31:0] cur_rate;
	logic [31:0] diff;
	logic [15:0] iv_sel;
	logic [15:0] n_eff;
	logic [2:0]  wx;
	logic [16:0] trial;
	logic        q_bit;
	logic [31:0] quot;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);

	assign wx = 3'(w_q);
	assign row_rd = rate_q[w_q];
	assign cur_rate = row_rd[k_q];
	assign diff = d_q - cur_rate;
	assign trial = {rem_q, dvd_q[31]};
	assign q_bit = (trial >= {1'b0, n_q});
	assign quot = neg_q ? (32'd0 - dvd_q) : dvd_q;

	always_comb begin
		unique case (k_q)
			2'd0: sel_cnt = tx_frames_q;
			2'd1: sel_cnt = rx_frames_q;
			2'd2: sel_cnt = tx_bytes_q;
			2'd3: sel_cnt = rx_bytes_q;
			default: sel_cnt = tx_frames_q;
		endcase
		delta_raw = sel_cnt[31:0] - snap_q[k_q][31:0];
		delta_val = k_q[1] ? delta_raw : 32'(delta_raw * ftrm_pkg::FRAME_SCALE);
	end

	always_comb begin
		unique case (wx)
			3'd0: iv_sel = iv0_q;
			3'd1: iv_sel = iv1_q;
			default: iv_sel = iv2_q;
		endcase
		n_eff = (iv_sel == 16'd0) ? 16'd1 : iv_sel;
	end

	always_comb begin
		out_ch.data.window_index   = wx;
		out_ch.data.tx_frame_avg   = row_rd[0];
		out_ch.data.rx_frame_avg   = row_rd[1];
		out_ch.data.tx_byte_avg    = row_rd[2];
		out_ch.data.rx_byte_avg    = row_rd[3];
		out_ch.data.tx_frames      = tx_frames_q;
		out_ch.data.rx_frames      = rx_frames_q;
		out_ch.data.tx_total_bytes = tx_bytes_q;
		out_ch.data.rx_total_bytes = rx_bytes_q;
		out_ch.data.tx_error_total = tx_err_q;
		out_ch.data.last_window    = (w_q == W_LAST);
	end

	// interval registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv0_q <= ftrm_pkg::INTERVAL_0_RESET;
			iv1_q <= ftrm_pkg::INTERVAL_1_RESET;
			iv2_q <= ftrm_pkg::INTERVAL_2_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ftrm_pkg::CFG_INTERVAL_0: iv0_q <= cfg_wdata;
				ftrm_pkg::CFG_INTERVAL_1: iv1_q <= cfg_wdata;
				ftrm_pkg::CFG_INTERVAL_2: iv2_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// counters, rates and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			w_q         <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			d_q         <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			n_q         <= '0;
			neg_q       <= 1'b0;
			tx_frames_q <= '0;
			rx_frames_q <= '0;
			tx_bytes_q  <= '0;
			rx_bytes_q  <= '0;
			tx_err_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				snap_q[i] <= '0;
			end
			for (int i = 0; i < RATE_WINDOWS; i++) begin
				rate_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						w_q     <= '0;
						k_q     <= '0;
						state_q <= ST_OUT;
						unique case (in_ch.data.opcode)
							ftrm_pkg::OP_TX_FRAME: begin
								tx_frames_q <= tx_frames_q + 64'd1;
								tx_bytes_q  <= tx_bytes_q + {48'd0, in_ch.data.frame_size};
							end
							ftrm_pkg::OP_TX_ERROR: tx_err_q <= tx_err_q + 64'd1;
							ftrm_pkg::OP_RX_FRAME: begin
								rx_frames_q <= rx_frames_q + 64'd1;
								rx_bytes_q  <= rx_bytes_q + {48'd0, in_ch.data.frame_size};
							end
							ftrm_pkg::OP_CLEAR: begin
								tx_frames_q <= '0;
								rx_frames_q <= '0;
								tx_bytes_q  <= '0;
								rx_bytes_q  <= '0;
								tx_err_q    <= '0;
								for (int i = 0; i < 4; i++) begin
									snap_q[i] <= '0;
								end
								for (int i = 0; i < RATE_WINDOWS; i++) begin
									rate_q[i] <= '0;
								end
							end
							ftrm_pkg::OP_TICK: state_q <= ST_DELTA;
							default: ;
						endcase
					end
				end
				ST_DELTA: begin
					d_q     <= delta_val;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					neg_q   <= diff[31];
					dvd_q   <= diff[31] ? (32'd0 - diff) : diff;
					rem_q   <= '0;
					n_q     <= n_eff;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= q_bit ? 16'(trial - {1'b0, n_q}) : trial[15:0];
					dvd_q <= {dvd_q[30:0], q_bit};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					rate_q[w_q][k_q] <= cur_rate + quot;
					if (w_q != W_LAST) begin
						w_q     <= w_q + WW'(1);
						state_q <= ST_LOAD;
					end else begin
						w_q <= '0;
						if (k_q != 2'd3) begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_DELTA;
						end else begin
							snap_q[0] <= tx_frames_q;
							snap_q[1] <= rx_frames_q;
							snap_q[2] <= tx_bytes_q;
							snap_q[3] <= rx_bytes_q;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (w_q == W_LAST) begin
							w_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							w_q <= w_q + WW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input taken while results pending");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (n_q != 16'd0))
		else $error("divider running with zero divisor");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_ch.data.last_window) |=> in_ch.ready)
		else $error("not idle after final result");

	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.data.opcode != ftrm_pkg::OP_TICK) |=>
		(out_ch.valid && out_ch.data.window_index == 3'd0))
		else $error("non-tick word did not report at once");
`endif

endmodule

// ===== tb/sv/frame_traffic_rate_meter_tb.sv =====
// frame_traffic_rate_meter_tb: self-checking testbench of the frame traffic rate meter
// a directed table then random words under several idle and stall phases, every
// result word checked against a predictor; depends on ftrm_pkg, ftrm_in_if, ftrm_out_if
module frame_traffic_rate_meter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOWS = 3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_WORDS = 98;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [ftrm_pkg::CfgIndexWidth-1:0] CFG_SPARE = 2'd3;

	typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		logic [2:0]                         op;
		logic [15:0]                        arg;
		logic [ftrm_pkg::CfgIndexWidth-1:0] idx;
		bit                                 known;
		logic [63:0]                        e_tx;
		logic [63:0]                        e_rx;
		logic [63:0]                        e_txb;
		logic [63:0]                        e_rxb;
		logic [63:0]                        e_err;
	} stim_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [ftrm_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [ftrm_pkg::IntervalWidth-1:0] cfg_wdata;

	ftrm_in_if  in_ch();
	ftrm_out_if out_ch();

	frame_traffic_rate_meter #(
		.RATE_WINDOWS(WINDOWS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// predicted meter state
	logic [63:0] tx_frames_m;
	logic [63:0] rx_frames_m;
	logic [63:0] tx_bytes_m;
	logic [63:0] rx_bytes_m;
	logic [63:0] tx_errors_m;
	logic [63:0] snap_m [4];
	logic [31:0] rate_m [WINDOWS][4];
	logic [15:0] interval_m [3];

	ftrm_pkg::out_word_t fresh_reports [WINDOWS];
	ftrm_pkg::out_word_t report_q [$];
	stim_row_t           directed_rows [$];

	int          gap_pct = 0;
	int          stall_pct = 0;
	int          hold_requests = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [31:0] smoothed_rate(logic [31:0] rate, logic [31:0] delta,
			logic [15:0] n);
		int diff;
		int div;
		int q;
		diff = delta - rate;
		div = (n == 16'd0) ? 1 : int'(n);
		q = diff / div;
		return rate + q;
	endfunction

	function automatic void clear_meter();
		tx_frames_m = '0;
		rx_frames_m = '0;
		tx_bytes_m = '0;
		rx_bytes_m = '0;
		tx_errors_m = '0;
		for (int k = 0; k < 4; k++) begin
			snap_m[k] = '0;
			for (int w = 0; w < WINDOWS; w++) rate_m[w][k] = '0;
		end
	endfunction

	function automatic void update_meter(ftrm_pkg::in_word_t word);
		logic [63:0] scaled;
		logic [31:0] delta [4];
		logic [15:0] n;
		case (word.opcode)
			ftrm_pkg::OP_TX_FRAME: begin
				tx_frames_m = tx_frames_m + 64'd1;
				tx_bytes_m = tx_bytes_m + 64'(word.frame_size);
			end
			ftrm_pkg::OP_TX_ERROR: tx_errors_m = tx_errors_m + 64'd1;
			ftrm_pkg::OP_RX_FRAME: begin
				rx_frames_m = rx_frames_m + 64'd1;
				rx_bytes_m = rx_bytes_m + 64'(word.frame_size);
			end
			ftrm_pkg::OP_CLEAR: clear_meter();
			ftrm_pkg::OP_TICK: begin
				scaled = (tx_frames_m - snap_m[0]) * 64'd1000;
				delta[0] = scaled[31:0];
				scaled = (rx_frames_m - snap_m[1]) * 64'd1000;
				delta[1] = scaled[31:0];
				scaled = tx_bytes_m - snap_m[2];
				delta[2] = scaled[31:0];
				scaled = rx_bytes_m - snap_m[3];
				delta[3] = scaled[31:0];
				for (int w = 0; w < WINDOWS; w++) begin
					n = interval_m[(w < 3) ? w : 2];
					for (int k = 0; k < 4; k++) begin
						rate_m[w][k] = smoothed_rate(rate_m[w][k], delta[k], n);
					end
				end
				snap_m[0] = tx_frames_m;
				snap_m[1] = rx_frames_m;
				snap_m[2] = tx_bytes_m;
				snap_m[3] = rx_bytes_m;
			end
			default: ;
		endcase
		for (int w = 0; w < WINDOWS; w++) begin
			fresh_reports[w].window_index = 3'(w);
			fresh_reports[w].tx_frame_avg = rate_m[w][0];
			fresh_reports[w].rx_frame_avg = rate_m[w][1];
			fresh_reports[w].tx_byte_avg = rate_m[w][2];
			fresh_reports[w].rx_byte_avg = rate_m[w][3];
			fresh_reports[w].tx_frames = tx_frames_m;
			fresh_reports[w].rx_frames = rx_frames_m;
			fresh_reports[w].tx_total_bytes = tx_bytes_m;
			fresh_reports[w].rx_total_bytes = rx_bytes_m;
			fresh_reports[w].tx_error_total = tx_errors_m;
			fresh_reports[w].last_window = (w == WINDOWS - 1);
		end
	endfunction

	function automatic stim_row_t word_row(logic [2:0] op, logic [15:0] size);
		stim_row_t r;
		r.kind = ROW_WORD;
		r.op = op;
		r.arg = size;
		r.idx = '0;
		r.known = 1'b0;
		r.e_tx = '0;
		r.e_rx = '0;
		r.e_txb = '0;
		r.e_rxb = '0;
		r.e_err = '0;
		return r;
	endfunction

	function automatic stim_row_t known_row(logic [2:0] op, logic [15:0] size, logic [63:0] tx,
			logic [63:0] rx, logic [63:0] txb, logic [63:0] rxb, logic [63:0] err);
		stim_row_t r;
		r = word_row(op, size);
		r.known = 1'b1;
		r.e_tx = tx;
		r.e_rx = rx;
		r.e_txb = txb;
		r.e_rxb = rxb;
		r.e_err = err;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [ftrm_pkg::CfgIndexWidth-1:0] idx,
			logic [15:0] value);
		stim_row_t r;
		r = word_row(ftrm_pkg::OP_TX_FRAME, value);
		r.kind = ROW_CFG;
		r.idx = idx;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// result side: checks every word and drives ready, with a long hold on request
	initial begin
		ftrm_pkg::out_word_t want;
		int hold_left;
		int hold_served;
		hold_left = 0;
		hold_served = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				if (report_q.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result word: expected none, actual %h", $time,
						out_ch.data);
				end else begin
					want = report_q.pop_front();
					check_field("window_index", want.window_index, out_ch.data.window_index);
					check_field("tx_frame_avg", want.tx_frame_avg, out_ch.data.tx_frame_avg);
					check_field("rx_frame_avg", want.rx_frame_avg, out_ch.data.rx_frame_avg);
					check_field("tx_byte_avg", want.tx_byte_avg, out_ch.data.tx_byte_avg);
					check_field("rx_byte_avg", want.rx_byte_avg, out_ch.data.rx_byte_avg);
					check_field("tx_frames", want.tx_frames, out_ch.data.tx_frames);
					check_field("rx_frames", want.rx_frames, out_ch.data.rx_frames);
					check_field("tx_total_bytes", want.tx_total_bytes,
						out_ch.data.tx_total_bytes);
					check_field("rx_total_bytes", want.rx_total_bytes,
						out_ch.data.rx_total_bytes);
					check_field("tx_error_total", want.tx_error_total,
						out_ch.data.tx_error_total);
					check_field("last_window", want.last_window, out_ch.data.last_window);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_word(stim_row_t r);
		ftrm_pkg::in_word_t word;
		word.opcode = r.op;
		word.frame_size = r.arg;
		while ($urandom_range(99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= word;
		do @(posedge clk); while (!in_ch.ready);
		update_meter(word);
		for (int w = 0; w < WINDOWS; w++) begin
			if (r.known) begin
				fresh_reports[w].tx_frames = r.e_tx;
				fresh_reports[w].rx_frames = r.e_rx;
				fresh_reports[w].tx_total_bytes = r.e_txb;
				fresh_reports[w].rx_total_bytes = r.e_rxb;
				fresh_reports[w].tx_error_total = r.e_err;
			end
			report_q.push_back(fresh_reports[w]);
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [ftrm_pkg::CfgIndexWidth-1:0] idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx < 3) interval_m[idx] = value;
	endtask

	task automatic program_windows(logic [15:0] n0, logic [15:0] n1, logic [15:0] n2);
		drain();
		write_reg(ftrm_pkg::CFG_INTERVAL_0, n0);
		write_reg(ftrm_pkg::CFG_INTERVAL_1, n1);
		write_reg(ftrm_pkg::CFG_INTERVAL_2, n2);
		write_reg(CFG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	function automatic stim_row_t random_row();
		int pick;
		logic [15:0] size;
		logic [2:0] op;
		pick = $urandom_range(99);
		if (pick < 10) size = 16'd0;
		else if (pick < 20) size = 16'hffff;
		else size = 16'($urandom_range(65535));
		pick = $urandom_range(99);
		if (pick < 35) op = ftrm_pkg::OP_TX_FRAME;
		else if (pick < 65) op = ftrm_pkg::OP_RX_FRAME;
		else if (pick < 75) op = ftrm_pkg::OP_TX_ERROR;
		else if (pick < 90) op = ftrm_pkg::OP_TICK;
		else if (pick < 93) op = ftrm_pkg::OP_CLEAR;
		else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		return word_row(op, size);
	endfunction

	initial begin
		stim_row_t r;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		clear_meter();
		interval_m[0] = ftrm_pkg::INTERVAL_0_RESET;
		interval_m[1] = ftrm_pkg::INTERVAL_1_RESET;
		interval_m[2] = ftrm_pkg::INTERVAL_2_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_rows.push_back(known_row(ftrm_pkg::OP_TX_FRAME, 16'd0, 1, 0, 0, 0, 0));
		directed_rows.push_back(known_row(ftrm_pkg::OP_TX_FRAME, 16'hffff, 2, 0, 65535, 0, 0));
		directed_rows.push_back(known_row(ftrm_pkg::OP_RX_FRAME, 16'hffff, 2, 1, 65535, 65535,
			0));
		directed_rows.push_back(known_row(ftrm_pkg::OP_RX_FRAME, 16'h5555, 2, 2, 65535, 87380,
			0));
		directed_rows.push_back(known_row(ftrm_pkg::OP_TX_ERROR, 16'haaaa, 2, 2, 65535, 87380,
			1));
		directed_rows.push_back(known_row(OP_SPARE_LO, 16'hffff, 2, 2, 65535, 87380, 1));
		directed_rows.push_back(known_row(3'd6, 16'h1234, 2, 2, 65535, 87380, 1));
		directed_rows.push_back(known_row(OP_SPARE_HI, 16'h8000, 2, 2, 65535, 87380, 1));
		directed_rows.push_back(known_row(ftrm_pkg::OP_TICK, 16'hffff, 2, 2, 65535, 87380, 1));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TICK, 16'd0));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TX_FRAME, 16'd1234));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TICK, 16'd0));
		directed_rows.push_back(known_row(ftrm_pkg::OP_CLEAR, 16'hffff, 0, 0, 0, 0, 0));
		directed_rows.push_back(known_row(ftrm_pkg::OP_TICK, 16'd0, 0, 0, 0, 0, 0));
		directed_rows.push_back(word_row(ftrm_pkg::OP_RX_FRAME, 16'hffff));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TICK, 16'd0));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TICK, 16'd0));
		// zero interval, largest interval, unit interval, and a write to no register
		directed_rows.push_back(cfg_row(ftrm_pkg::CFG_INTERVAL_0, 16'd0));
		directed_rows.push_back(cfg_row(ftrm_pkg::CFG_INTERVAL_1, 16'hffff));
		directed_rows.push_back(cfg_row(ftrm_pkg::CFG_INTERVAL_2, 16'd1));
		directed_rows.push_back(cfg_row(CFG_SPARE, 16'hffff));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TX_FRAME, 16'hffff));
		directed_rows.push_back(word_row(ftrm_pkg::OP_RX_FRAME, 16'h00ff));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TICK, 16'd0));
		directed_rows.push_back(word_row(ftrm_pkg::OP_TICK, 16'd0));
		directed_rows.push_back(known_row(ftrm_pkg::OP_CLEAR, 16'd0, 0, 0, 0, 0, 0));

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.kind == ROW_CFG) begin
				drain();
				write_reg(r.idx, r.arg);
				cfg_we <= 1'b0;
			end else begin
				send_word(r);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: program_windows(16'd1, 16'd1, 16'd1);
				1: program_windows(16'hffff, 16'd0, 16'd2);
				2: program_windows(16'($urandom_range(1, 20)), 16'($urandom_range(1, 65535)),
					16'($urandom_range(1, 8)));
				default: program_windows(16'd3, 16'hffff, 16'd1);
			endcase
			gap_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 27) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 88 : 27) : 0;
			// long receiver hold while words keep coming
			if (ph == 0) hold_requests++;
			for (int n = 0; n < PHASE_WORDS; n++) send_word(random_row());
		end

		drain();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
